FILE: rtl/core/mp3sip_pkg.sv
// ----------------------------------------------------------------------------
// mp3sip_pkg: shared types and constants of the side info parser
// Word formats, parse state layout, step codes and the per-step field tables.
// ----------------------------------------------------------------------------
package mp3sip_pkg;

	localparam int MAX_RESULTS = 8;
	localparam int CNT_W       = 4;

	// parse steps
	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_SYNC  = 5'd1;
	localparam logic [4:0] ST_VER   = 5'd2;
	localparam logic [4:0] ST_LAYER = 5'd3;
	localparam logic [4:0] ST_PROT  = 5'd4;
	localparam logic [4:0] ST_MODE  = 5'd9;
	localparam logic [4:0] ST_EMPH  = 5'd13;
	localparam logic [4:0] ST_CRC   = 5'd14;
	localparam logic [4:0] ST_MDB   = 5'd15;
	localparam logic [4:0] ST_PRIV  = 5'd16;
	localparam logic [4:0] ST_SCFSI = 5'd17;
	localparam logic [4:0] ST_P23L  = 5'd18;
	localparam logic [4:0] ST_BIGV  = 5'd19;
	localparam logic [4:0] ST_WSF   = 5'd22;
	localparam logic [4:0] ST_BT    = 5'd23;
	localparam logic [4:0] ST_TS    = 5'd25;
	localparam logic [4:0] ST_SBG   = 5'd26;
	localparam logic [4:0] ST_R0    = 5'd27;
	localparam logic [4:0] ST_R1    = 5'd28;
	localparam logic [4:0] ST_PRE   = 5'd29;
	localparam logic [4:0] ST_C1T   = 5'd31;

	localparam logic [4:0] FC_VERSION = 5'd0;
	localparam logic [4:0] NO_CODE    = 5'd31;

	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_BAD_SYNC   = 2'd1;
	localparam logic [1:0] STAT_BAD_FORMAT = 2'd2;
	localparam logic [1:0] STAT_BIGV_OVER  = 2'd3;

	localparam logic [10:0] SYNC_WORD      = 11'h7ff;
	localparam logic [11:0] BIGV_LIMIT     = 12'd288;
	localparam logic [1:0]  VERSION_MPEG1  = 2'd3;
	localparam logic [1:0]  LAYER_III      = 2'd1;
	localparam logic [1:0]  MODE_MONO      = 2'd3;
	localparam logic [1:0]  CRC_BYTES      = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       frame_start;
	} in_word_t;

	typedef struct packed {
		logic [4:0]  field_code;
		logic [11:0] field_value;
		logic        granule_no;
		logic        channel_no;
		logic [1:0]  sub_index;
		logic [1:0]  status;
		logic        last_field;
	} out_word_t;

	typedef out_word_t [MAX_RESULTS-1:0] out_list_t;

	typedef struct packed {
		logic [4:0]  step;
		logic [11:0] acc;
		logic [3:0]  bits;
		logic        gr;
		logic        ch;
		logic        stereo;
		logic        sw;
		logic [1:0]  crc_left;
		logic [1:0]  list_pos;
		logic        fmt_bad;
	} parse_state_t;

	function automatic logic [3:0] step_width(input logic [4:0] s);
		logic [3:0] w;
		case (s)
			5'd1: w = 4'd11;
			5'd2, 5'd3, 5'd6, 5'd9, 5'd10, 5'd13: w = 4'd2;
			5'd4, 5'd7, 5'd8, 5'd11, 5'd12, 5'd22, 5'd24, 5'd29, 5'd30, 5'd31: w = 4'd1;
			5'd5, 5'd17, 5'd21, 5'd27: w = 4'd4;
			5'd15, 5'd19: w = 4'd9;
			5'd16, 5'd25: w = 4'd5;
			5'd18: w = 4'd12;
			5'd20: w = 4'd8;
			5'd23: w = 4'd2;
			5'd26, 5'd28: w = 4'd3;
			default: w = 4'd0;
		endcase
		return w;
	endfunction

	function automatic logic [4:0] step_code(input logic [4:0] s);
		logic [4:0] c;
		case (s)
			5'd2: c = 5'd0;
			5'd3: c = 5'd1;
			5'd4: c = 5'd2;
			5'd5: c = 5'd3;
			5'd6: c = 5'd4;
			5'd7: c = 5'd5;
			5'd9: c = 5'd6;
			5'd10: c = 5'd7;
			default: c = (s >= ST_MDB) ? 5'(s - 5'd7) : NO_CODE;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/core/mp3_side_info_parser_core.sv
// ----------------------------------------------------------------------------
// mp3_side_info_parser_core: MPEG-1 Layer III header and side info parser
// Input register, one-byte parse step, parse state register and a result
// buffer that drains the fields one word per cycle while field_ready is high.
//
//   channel   signals                          word
//   byte in   byte_valid / byte_ready          byte_word  (in_byte, frame_start)
//   field out field_valid / field_ready        field_word (code, value, tags)
//
// A byte is registered when taken and parsed in the next cycle; its fields
// load into the buffer as it advances and appear in the cycle after. Throughput
// is one byte per cycle while bytes complete at most one field and field_ready
// stays high; a byte with more fields holds the next byte with fields until the
// buffer's single output port drains them. Bytes with no field pass meanwhile.
// Reset returns the parser to idle and empties the buffer.
// ----------------------------------------------------------------------------
module mp3_side_info_parser_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  mp3sip_pkg::in_word_t  byte_word,
	output logic                  field_valid,
	input  logic                  field_ready,
	output mp3sip_pkg::out_word_t field_word
);

	logic                         byte_vld_s1;
	mp3sip_pkg::in_word_t         byte_s1;
	mp3sip_pkg::parse_state_t     state_q;
	mp3sip_pkg::parse_state_t     state_nxt;
	mp3sip_pkg::out_list_t        list;
	logic [mp3sip_pkg::CNT_W-1:0] count;
	logic                         batch_free;
	logic                         advance;
	logic                         load_batch;

	mp3sip_parse u_parse (
		.cur   (state_q),
		.word  (byte_s1),
		.nxt   (state_nxt),
		.list  (list),
		.count (count)
	);

	// a byte with no fields never waits for the buffer
	assign advance    = byte_vld_s1 && (batch_free || count == '0);
	assign load_batch = advance && count != '0;
	assign byte_ready = !byte_vld_s1 || advance;

	mp3sip_batch u_batch (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load_batch),
		.list        (list),
		.count       (count),
		.free        (batch_free),
		.field_valid (field_valid),
		.field_ready (field_ready),
		.field_word  (field_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_vld_s1 <= 1'b0;
			state_q     <= '0;
		end else begin
			if (byte_ready)
				byte_vld_s1 <= byte_valid;
			if (advance)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready)
			byte_s1 <= byte_word;
	end

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load_batch |=> field_valid)
		else $error("loaded fields not presented");

	a_crc_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.step == mp3sip_pkg::ST_CRC |-> state_q.crc_left != 2'd0)
		else $error("CRC skip with nothing left");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		field_valid && (field_word.status == mp3sip_pkg::STAT_BAD_SYNC ||
		field_word.status == mp3sip_pkg::STAT_BAD_FORMAT) |-> field_word.last_field)
		else $error("error word without last_field");

	a_hold_parse: assert property (@(posedge clk) disable iff (!arst_n)
		byte_vld_s1 && !advance |=> byte_vld_s1 && $stable(state_q))
		else $error("parse state moved on a stalled byte");

endmodule

FILE: rtl/core/mp3sip_parse.sv
// ----------------------------------------------------------------------------
// mp3sip_parse: one-byte parse step
// Shifts the eight bits of a byte MSB first through the field collector and
// returns the next parse state plus the list of fields completed by the byte.
// ----------------------------------------------------------------------------
module mp3sip_parse (
	input  mp3sip_pkg::parse_state_t       cur,
	input  mp3sip_pkg::in_word_t           word,
	output mp3sip_pkg::parse_state_t       nxt,
	output mp3sip_pkg::out_list_t          list,
	output logic [mp3sip_pkg::CNT_W-1:0]   count
);

	function automatic mp3sip_pkg::out_word_t mk(input logic [4:0] c, input logic [11:0] v,
			input logic g, input logic h, input logic [1:0] sub, input logic [1:0] stat,
			input logic last);
		mp3sip_pkg::out_word_t r;
		r.field_code  = c;
		r.field_value = v;
		r.granule_no  = g;
		r.channel_no  = h;
		r.sub_index   = sub;
		r.status      = stat;
		r.last_field  = last;
		return r;
	endfunction

	always_comb begin
		mp3sip_pkg::parse_state_t st;
		logic                      run;
		logic [3:0]                w;
		logic [11:0]               v;
		logic [4:0]                s;
		logic [4:0]                code;
		logic [4:0]                nstep;
		logic                      g;
		logic                      h;
		logic [1:0]                limit;
		logic [1:0]                lp;
		logic                      lastf;
		logic [1:0]                stat;
		logic [mp3sip_pkg::CNT_W-1:0] n;

		st    = cur;
		list  = '0;
		n     = '0;
		run   = 1'b1;
		w     = '0;
		v     = '0;
		s     = '0;
		code  = '0;
		nstep = '0;
		g     = 1'b0;
		h     = 1'b0;
		limit = '0;
		lp    = '0;
		lastf = 1'b0;
		stat  = '0;
		if (word.frame_start) begin
			st      = '0;
			st.step = mp3sip_pkg::ST_SYNC;
		end
		if (st.step == mp3sip_pkg::ST_IDLE) begin
			run = 1'b0;
		end else if (st.step == mp3sip_pkg::ST_CRC) begin
			// CRC bytes are dropped whole
			run = 1'b0;
			if (st.crc_left != 2'd0)
				st.crc_left = st.crc_left - 2'd1;
			if (st.crc_left == 2'd0)
				st.step = mp3sip_pkg::ST_MDB;
		end

		for (int i = 7; i >= 0; i--) begin
			if (st.step == mp3sip_pkg::ST_IDLE || st.step == mp3sip_pkg::ST_CRC)
				run = 1'b0;
			if (run) begin
				w = mp3sip_pkg::step_width(st.step);
				if (st.step == mp3sip_pkg::ST_PRIV)
					w = st.stereo ? 4'd3 : 4'd5;
				st.acc  = {st.acc[10:0], word.in_byte[3'(i)]};
				st.bits = st.bits + 4'd1;
				if (st.bits >= w) begin
					v       = st.acc;
					st.acc  = '0;
					st.bits = '0;
					s       = st.step;
					code    = mp3sip_pkg::step_code(s);
					g       = (s >= mp3sip_pkg::ST_P23L) ? st.gr : 1'b0;
					h       = (s >= mp3sip_pkg::ST_SCFSI) ? st.ch : 1'b0;
					nstep   = s + 5'd1;
					if (s == mp3sip_pkg::ST_SYNC && v[10:0] != mp3sip_pkg::SYNC_WORD) begin
						list[n[2:0]] = mk(mp3sip_pkg::FC_VERSION, v, 1'b0, 1'b0, 2'd0,
							mp3sip_pkg::STAT_BAD_SYNC, 1'b1);
						n     = n + 4'd1;
						nstep = mp3sip_pkg::ST_IDLE;
					end else begin
						if (s == mp3sip_pkg::ST_VER)
							st.fmt_bad = (v[1:0] != mp3sip_pkg::VERSION_MPEG1);
						if (s == mp3sip_pkg::ST_LAYER && v[1:0] != mp3sip_pkg::LAYER_III)
							st.fmt_bad = 1'b1;
						if (s == mp3sip_pkg::ST_PROT)
							st.crc_left = (v[0] == 1'b0) ? mp3sip_pkg::CRC_BYTES : 2'd0;
						if (s == mp3sip_pkg::ST_MODE)
							st.stereo = (v[1:0] != mp3sip_pkg::MODE_MONO);

						stat = (s == mp3sip_pkg::ST_BIGV && v > mp3sip_pkg::BIGV_LIMIT) ?
							mp3sip_pkg::STAT_BIGV_OVER : mp3sip_pkg::STAT_OK;
						if (code != mp3sip_pkg::NO_CODE && s != mp3sip_pkg::ST_TS &&
								s != mp3sip_pkg::ST_SBG && s != mp3sip_pkg::ST_C1T) begin
							list[n[2:0]] = mk(code, v, g, h, 2'd0, stat, 1'b0);
							n = n + 4'd1;
						end

						case (s)
							mp3sip_pkg::ST_EMPH: begin
								if (st.fmt_bad) begin
									list[n[2:0]] = mk(mp3sip_pkg::FC_VERSION, 12'd0, 1'b0,
										1'b0, 2'd0, mp3sip_pkg::STAT_BAD_FORMAT, 1'b1);
									n     = n + 4'd1;
									nstep = mp3sip_pkg::ST_IDLE;
								end else begin
									nstep = (st.crc_left != 2'd0) ? mp3sip_pkg::ST_CRC :
										mp3sip_pkg::ST_MDB;
								end
							end
							mp3sip_pkg::ST_SCFSI: begin
								if (st.stereo && !st.ch) begin
									st.ch = 1'b1;
									nstep = mp3sip_pkg::ST_SCFSI;
								end else begin
									st.ch = 1'b0;
									st.gr = 1'b0;
									nstep = mp3sip_pkg::ST_P23L;
								end
							end
							mp3sip_pkg::ST_WSF: begin
								st.sw = v[0];
								nstep = v[0] ? mp3sip_pkg::ST_BT : mp3sip_pkg::ST_TS;
							end
							mp3sip_pkg::ST_TS, mp3sip_pkg::ST_SBG: begin
								limit = (s == mp3sip_pkg::ST_TS && st.sw) ? 2'd2 : 2'd3;
								list[n[2:0]] = mk(code, v, g, h, st.list_pos,
									mp3sip_pkg::STAT_OK, 1'b0);
								n  = n + 4'd1;
								lp = st.list_pos + 2'd1;
								if (lp >= limit) begin
									st.list_pos = 2'd0;
									if (s == mp3sip_pkg::ST_TS)
										nstep = st.sw ? mp3sip_pkg::ST_SBG : mp3sip_pkg::ST_R0;
									else
										nstep = mp3sip_pkg::ST_PRE;
								end else begin
									st.list_pos = lp;
									nstep       = s;
								end
							end
							mp3sip_pkg::ST_R1: begin
								nstep = mp3sip_pkg::ST_PRE;
							end
							mp3sip_pkg::ST_C1T: begin
								lastf = st.gr && (!st.stereo || st.ch);
								list[n[2:0]] = mk(code, v, g, h, 2'd0, mp3sip_pkg::STAT_OK,
									lastf);
								n = n + 4'd1;
								if (st.stereo && !st.ch) begin
									st.ch = 1'b1;
									nstep = mp3sip_pkg::ST_P23L;
								end else begin
									st.ch = 1'b0;
									if (!st.gr) begin
										st.gr = 1'b1;
										nstep = mp3sip_pkg::ST_P23L;
									end else begin
										nstep = mp3sip_pkg::ST_IDLE;
									end
								end
							end
							default: begin
							end
						endcase
					end
					st.step = nstep;
				end
			end
		end
		nxt   = st;
		count = n;
	end

endmodule

FILE: rtl/core/mp3sip_batch.sv
// ----------------------------------------------------------------------------
// mp3sip_batch: result buffer
// Holds one byte's fields and hands them out one word a cycle while ready.
// ----------------------------------------------------------------------------
module mp3sip_batch (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  mp3sip_pkg::out_list_t        list,
	input  logic [mp3sip_pkg::CNT_W-1:0] count,
	output logic                         free,
	output logic                         field_valid,
	input  logic                         field_ready,
	output mp3sip_pkg::out_word_t        field_word
);

	mp3sip_pkg::out_list_t        entries_q;
	logic [mp3sip_pkg::CNT_W-1:0] total_q;
	logic [mp3sip_pkg::CNT_W-1:0] rd_q;
	logic                         take;

	assign field_valid = (rd_q != total_q);
	assign take        = field_valid && field_ready;
	// free when empty or the last word leaves this cycle
	assign free        = !field_valid || (take && (rd_q + 4'd1 == total_q));
	assign field_word  = entries_q[rd_q[2:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			rd_q    <= '0;
		end else if (load) begin
			total_q <= count;
			rd_q    <= '0;
		end else if (take) begin
			rd_q <= rd_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			entries_q <= list;
	end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: frame header and side info parser, self-checking
// Streams whole and broken frames through the byte channel with random gaps,
// predicts every field word from its own bit-level parser and checks each
// field word in order against the output channel, which stalls at random.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT  = 60000;
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_BYTES = 120;
	localparam int DRAIN_CYCLES = 20;

	// parse steps with no name in the package
	localparam logic [4:0] ST_BITRATE = 5'd5;
	localparam logic [4:0] ST_SFREQ   = 5'd6;
	localparam logic [4:0] ST_PAD     = 5'd7;
	localparam logic [4:0] ST_PRIVBIT = 5'd8;
	localparam logic [4:0] ST_MODEXT  = 5'd10;
	localparam logic [4:0] ST_COPY    = 5'd11;
	localparam logic [4:0] ST_ORIG    = 5'd12;
	localparam logic [4:0] ST_GGAIN   = 5'd20;
	localparam logic [4:0] ST_SFC     = 5'd21;
	localparam logic [4:0] ST_MIXED   = 5'd24;
	localparam logic [4:0] ST_SFSCALE = 5'd30;

	localparam logic [4:0] FC_LAYER    = 5'd1;
	localparam logic [4:0] FC_PROT     = 5'd2;
	localparam logic [4:0] FC_BITRATE  = 5'd3;
	localparam logic [4:0] FC_SFREQ    = 5'd4;
	localparam logic [4:0] FC_PAD      = 5'd5;
	localparam logic [4:0] FC_MODE     = 5'd6;
	localparam logic [4:0] FC_MODEXT   = 5'd7;
	// side info codes follow the step number at this offset
	localparam logic [4:0] SIDE_CODE_OFS = 5'd7;

	typedef enum int {FRM_GOOD, FRM_BAD_SYNC, FRM_BAD_FMT, FRM_CUT} frame_kind_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  byte_valid = 1'b0;
	logic                  byte_ready;
	mp3sip_pkg::in_word_t  byte_word = '0;
	logic                  field_valid;
	logic                  field_ready = 1'b0;
	mp3sip_pkg::out_word_t field_word;

	mp3_side_info_parser_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_word  (byte_word),
		.field_valid(field_valid),
		.field_ready(field_ready),
		.field_word (field_word)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	mp3sip_pkg::in_word_t  byte_q[$];
	mp3sip_pkg::out_word_t expected_fields[$];

	int cycles = 0;
	int err_count = 0;
	int fields_seen = 0;
	int bytes_offered = 0;
	int frames_built = 0;
	int byte_fields = 0;
	int hold_count = 0;
	logic in_accepted = 1'b0;
	logic out_accepted = 1'b0;

	// parser state kept by the predictor
	logic [4:0]  pstep = mp3sip_pkg::ST_IDLE;
	logic [11:0] acc = '0;
	logic [3:0]  nbits = '0;
	logic        gr = 1'b0;
	logic        ch = 1'b0;
	logic        stereo = 1'b0;
	logic        sw = 1'b0;
	logic [1:0]  crc_left = '0;
	logic [1:0]  lpos = '0;
	logic        fmt_bad = 1'b0;

	task automatic post(input logic [4:0] code, input logic [11:0] val, input logic g,
			input logic c, input logic [1:0] sub, input logic [1:0] st, input logic lst);
		if (byte_fields < mp3sip_pkg::MAX_RESULTS) begin
			expected_fields.push_back('{field_code: code, field_value: val, granule_no: g,
				channel_no: c, sub_index: sub, status: st, last_field: lst});
			byte_fields++;
		end
	endtask

	// Shift one byte MSB first through the field syntax; queue each finished field.
	task automatic parse_byte(input mp3sip_pkg::in_word_t w);
		logic [4:0]  s;
		logic [4:0]  nxt;
		logic [4:0]  code;
		logic [3:0]  wd;
		logic [11:0] v;
		logic [1:0]  limit;
		logic        g;
		logic        c;
		logic        lst;
		byte_fields = 0;
		if (w.frame_start) begin
			pstep = mp3sip_pkg::ST_SYNC;
			acc = '0;
			nbits = '0;
			gr = 1'b0;
			ch = 1'b0;
			stereo = 1'b0;
			sw = 1'b0;
			crc_left = '0;
			lpos = '0;
			fmt_bad = 1'b0;
		end
		if (pstep == mp3sip_pkg::ST_IDLE)
			return;
		if (pstep == mp3sip_pkg::ST_CRC) begin
			if (crc_left != 0)
				crc_left = crc_left - 2'd1;
			if (crc_left == 0)
				pstep = mp3sip_pkg::ST_MDB;
			return;
		end
		for (int i = 7; i >= 0; i--) begin
			if (pstep == mp3sip_pkg::ST_IDLE || pstep == mp3sip_pkg::ST_CRC)
				break;
			case (pstep)
				mp3sip_pkg::ST_SYNC: wd = 4'd11;
				mp3sip_pkg::ST_VER, mp3sip_pkg::ST_LAYER, ST_SFREQ, mp3sip_pkg::ST_MODE,
				ST_MODEXT, mp3sip_pkg::ST_EMPH, mp3sip_pkg::ST_BT: wd = 4'd2;
				mp3sip_pkg::ST_PROT, ST_PAD, ST_PRIVBIT, ST_COPY, ST_ORIG,
				mp3sip_pkg::ST_WSF, ST_MIXED, mp3sip_pkg::ST_PRE, ST_SFSCALE,
				mp3sip_pkg::ST_C1T: wd = 4'd1;
				ST_BITRATE, mp3sip_pkg::ST_SCFSI, ST_SFC, mp3sip_pkg::ST_R0: wd = 4'd4;
				mp3sip_pkg::ST_MDB, mp3sip_pkg::ST_BIGV: wd = 4'd9;
				mp3sip_pkg::ST_PRIV: wd = stereo ? 4'd3 : 4'd5;
				mp3sip_pkg::ST_P23L: wd = 4'd12;
				ST_GGAIN: wd = 4'd8;
				mp3sip_pkg::ST_TS: wd = 4'd5;
				mp3sip_pkg::ST_SBG, mp3sip_pkg::ST_R1: wd = 4'd3;
				default: wd = 4'd0;
			endcase
			acc = {acc[10:0], w.in_byte[i]};
			nbits = nbits + 4'd1;
			if (nbits < wd)
				continue;
			v = acc;
			acc = '0;
			nbits = '0;
			s = pstep;
			case (s)
				mp3sip_pkg::ST_VER: code = mp3sip_pkg::FC_VERSION;
				mp3sip_pkg::ST_LAYER: code = FC_LAYER;
				mp3sip_pkg::ST_PROT: code = FC_PROT;
				ST_BITRATE: code = FC_BITRATE;
				ST_SFREQ: code = FC_SFREQ;
				ST_PAD: code = FC_PAD;
				mp3sip_pkg::ST_MODE: code = FC_MODE;
				ST_MODEXT: code = FC_MODEXT;
				default: code = (s >= mp3sip_pkg::ST_MDB) ? s - SIDE_CODE_OFS :
					mp3sip_pkg::NO_CODE;
			endcase
			g = (s >= mp3sip_pkg::ST_P23L) ? gr : 1'b0;
			c = (s >= mp3sip_pkg::ST_SCFSI) ? ch : 1'b0;
			nxt = s + 5'd1;
			if (s == mp3sip_pkg::ST_SYNC && v != {1'b0, mp3sip_pkg::SYNC_WORD}) begin
				post(mp3sip_pkg::FC_VERSION, v, 1'b0, 1'b0, 2'd0,
					mp3sip_pkg::STAT_BAD_SYNC, 1'b1);
				pstep = mp3sip_pkg::ST_IDLE;
				continue;
			end
			if (s == mp3sip_pkg::ST_VER)
				fmt_bad = (v[1:0] != mp3sip_pkg::VERSION_MPEG1);
			else if (s == mp3sip_pkg::ST_LAYER && v[1:0] != mp3sip_pkg::LAYER_III)
				fmt_bad = 1'b1;
			else if (s == mp3sip_pkg::ST_PROT)
				crc_left = v[0] ? 2'd0 : mp3sip_pkg::CRC_BYTES;
			else if (s == mp3sip_pkg::ST_MODE)
				stereo = (v[1:0] != mp3sip_pkg::MODE_MONO);
			if (code != mp3sip_pkg::NO_CODE && s != mp3sip_pkg::ST_TS &&
					s != mp3sip_pkg::ST_SBG && s != mp3sip_pkg::ST_C1T)
				post(code, v, g, c, 2'd0,
					(s == mp3sip_pkg::ST_BIGV && v > mp3sip_pkg::BIGV_LIMIT) ?
					mp3sip_pkg::STAT_BIGV_OVER : mp3sip_pkg::STAT_OK, 1'b0);
			case (s)
				mp3sip_pkg::ST_EMPH: begin
					if (fmt_bad) begin
						post(mp3sip_pkg::FC_VERSION, 12'd0, 1'b0, 1'b0, 2'd0,
							mp3sip_pkg::STAT_BAD_FORMAT, 1'b1);
						nxt = mp3sip_pkg::ST_IDLE;
					end else begin
						nxt = (crc_left != 0) ? mp3sip_pkg::ST_CRC : mp3sip_pkg::ST_MDB;
					end
				end
				mp3sip_pkg::ST_SCFSI: begin
					if (stereo && !ch) begin
						ch = 1'b1;
						nxt = mp3sip_pkg::ST_SCFSI;
					end else begin
						ch = 1'b0;
						gr = 1'b0;
						nxt = mp3sip_pkg::ST_P23L;
					end
				end
				mp3sip_pkg::ST_WSF: begin
					sw = v[0];
					nxt = sw ? mp3sip_pkg::ST_BT : mp3sip_pkg::ST_TS;
				end
				mp3sip_pkg::ST_TS, mp3sip_pkg::ST_SBG: begin
					limit = (s == mp3sip_pkg::ST_TS && sw) ? 2'd2 : 2'd3;
					post(code, v, g, c, lpos, mp3sip_pkg::STAT_OK, 1'b0);
					lpos = lpos + 2'd1;
					if (lpos >= limit) begin
						lpos = '0;
						nxt = (s == mp3sip_pkg::ST_TS) ?
							(sw ? mp3sip_pkg::ST_SBG : mp3sip_pkg::ST_R0) : mp3sip_pkg::ST_PRE;
					end else begin
						nxt = s;
					end
				end
				mp3sip_pkg::ST_R1: nxt = mp3sip_pkg::ST_PRE;
				mp3sip_pkg::ST_C1T: begin
					lst = gr && (!stereo || ch);
					post(code, v, g, c, 2'd0, mp3sip_pkg::STAT_OK, lst);
					if (stereo && !ch) begin
						ch = 1'b1;
						nxt = mp3sip_pkg::ST_P23L;
					end else begin
						ch = 1'b0;
						if (!gr) begin
							gr = 1'b1;
							nxt = mp3sip_pkg::ST_P23L;
						end else begin
							nxt = mp3sip_pkg::ST_IDLE;
						end
					end
				end
				default: ;
			endcase
			pstep = nxt;
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	task automatic add_byte(input logic [7:0] b, input logic fs);
		byte_q.push_back('{in_byte: b, frame_start: fs});
		bytes_offered++;
	endtask

	task automatic add_frame(input frame_kind_t kind);
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b3;
		logic [3:0] vl;
		int nbytes;
		b1 = {3'b111, mp3sip_pkg::VERSION_MPEG1, mp3sip_pkg::LAYER_III,
			1'($urandom_range(0, 1))};
		b3 = 8'($urandom);
		nbytes = 4 + (b1[0] ? 0 : 2) + ((b3[7:6] == mp3sip_pkg::MODE_MONO) ? 17 : 32);
		frames_built++;
		case (kind)
			FRM_BAD_SYNC: begin
				b0 = 8'($urandom);
				b1 = 8'($urandom);
				if (b0 == 8'hff && b1[7:5] == 3'b111)
					b1[5] = 1'b0;
				add_byte(b0, 1'b1);
				add_byte(b1, 1'b0);
				repeat ($urandom_range(0, 3))
					add_byte(8'($urandom), 1'b0);
			end
			FRM_BAD_FMT: begin
				vl = 4'($urandom);
				if (vl == {mp3sip_pkg::VERSION_MPEG1, mp3sip_pkg::LAYER_III})
					vl[3] = 1'b0;
				b1[4:1] = vl;
				add_byte(8'hff, 1'b1);
				add_byte(b1, 1'b0);
				add_byte(8'($urandom), 1'b0);
				add_byte(b3, 1'b0);
				repeat ($urandom_range(0, 2))
					add_byte(8'($urandom), 1'b0);
			end
			default: begin
				// a cut frame stops short; the next frame start restarts the parse
				if (kind == FRM_CUT)
					nbytes = $urandom_range(2, nbytes - 1);
				add_byte(8'hff, 1'b1);
				add_byte(b1, 1'b0);
				if (nbytes > 2)
					add_byte(8'($urandom), 1'b0);
				if (nbytes > 3)
					add_byte(b3, 1'b0);
				for (int k = 4; k < nbytes; k++)
					add_byte(8'($urandom), 1'b0);
			end
		endcase
	endtask

	// sender: one gap draw per word, with occasional gap-free stretches
	int tx_wait = 0;
	int tx_calm = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else if (!byte_valid || in_accepted) begin
			if (tx_wait > 0) begin
				tx_wait--;
				byte_valid <= 1'b0;
			end else if (byte_q.size() != 0) begin
				byte_word <= byte_q.pop_front();
				byte_valid <= 1'b1;
				if (tx_calm > 0) begin
					tx_calm--;
					tx_wait = 0;
				end else if ($urandom_range(0, 31) == 0) begin
					tx_calm = 24;
					tx_wait = 0;
				end else begin
					tx_wait = $urandom_range(0, 3);
				end
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls per word, plus one long hold-off to back up the input
	int rx_wait = 0;
	int rx_calm = 0;
	int hold_left = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			field_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			field_ready <= 1'b0;
		end else if (out_accepted && hold_count == 0 && fields_seen >= HOLD_AT) begin
			hold_count++;
			hold_left = HOLD_CYCLES;
			field_ready <= 1'b0;
		end else if (out_accepted || !field_ready) begin
			if (out_accepted) begin
				if (rx_calm > 0) begin
					rx_calm--;
					rx_wait = 0;
				end else if ($urandom_range(0, 31) == 0) begin
					rx_calm = 24;
					rx_wait = 0;
				end else begin
					rx_wait = $urandom_range(0, 3);
				end
			end
			if (rx_wait > 0) begin
				rx_wait--;
				field_ready <= 1'b0;
			end else begin
				field_ready <= 1'b1;
			end
		end
	end

	mp3sip_pkg::out_word_t want_w;
	mp3sip_pkg::out_word_t got_w;
	always @(posedge clk) begin
		cycles++;
		in_accepted <= byte_valid && byte_ready;
		out_accepted <= field_valid && field_ready;
		if (arst_n) begin
			if (field_valid && field_ready) begin
				fields_seen++;
				got_w = field_word;
				if (expected_fields.size() == 0) begin
					$error("field word with none expected: code %0d value %0d",
						got_w.field_code, got_w.field_value);
					err_count++;
				end else begin
					want_w = expected_fields.pop_front();
					check_field("field_code", want_w.field_code, got_w.field_code);
					check_field("field_value", want_w.field_value, got_w.field_value);
					check_field("granule_no", want_w.granule_no, got_w.granule_no);
					check_field("channel_no", want_w.channel_no, got_w.channel_no);
					check_field("sub_index", want_w.sub_index, got_w.sub_index);
					check_field("status", want_w.status, got_w.status);
					check_field("last_field", want_w.last_field, got_w.last_field);
				end
			end
			if (byte_valid && byte_ready)
				parse_byte(byte_word);
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		int r;
		// a stray byte with no frame open is dropped
		add_byte(8'hff, 1'b0);
		// restart mid-sync, then a sync word that fails
		add_byte(8'hff, 1'b1);
		add_byte(8'h00, 1'b1);
		add_byte(8'he0, 1'b0);
		// header with a wrong version
		add_byte(8'hff, 1'b1);
		add_byte({3'b111, 2'b10, mp3sip_pkg::LAYER_III, 1'b1}, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'hff, 1'b0);
		// mono frame with CRC and all-ones side info: long blocks off, too many
		// big-value pairs
		add_byte(8'hff, 1'b1);
		add_byte({3'b111, mp3sip_pkg::VERSION_MPEG1, mp3sip_pkg::LAYER_III, 1'b0}, 1'b0);
		add_byte(8'hff, 1'b0);
		add_byte({mp3sip_pkg::MODE_MONO, 6'h3f}, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b0);
		repeat (17)
			add_byte(8'hff, 1'b0);

		while (bytes_offered < RANDOM_BYTES + 31) begin
			r = $urandom_range(0, 9);
			if (r < 7)
				add_frame(FRM_GOOD);
			else if (r == 7)
				add_frame(FRM_BAD_SYNC);
			else if (r == 8)
				add_frame(FRM_BAD_FMT);
			else
				add_frame(FRM_CUT);
			// noise between frames: dropped when idle, parsed after a cut frame
			if ($urandom_range(0, 3) == 0)
				add_byte(8'($urandom), 1'b0);
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_q.size() != 0 || byte_valid)
			@(posedge clk);
		while (expected_fields.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d bytes in %0d frames, %0d field words checked",
			bytes_offered, frames_built, fields_seen);
		$display("summary: %0d long output stall(s), %0d cycles", hold_count, cycles);
		if (err_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
